### src/cfslc_pkg.sv
package cfslc_pkg;

  // field widths
  localparam int IdW      = 29;
  localparam int LenW     = 4;
  localparam int PayW     = 64;
  localparam int TickW    = 16;
  localparam int CharW    = 8;
  localparam int CntW     = 5;

  // largest data length printed
  localparam logic [LenW-1:0] MaxLen = 4'd8;

  // ascii codes
  localparam logic [CharW-1:0] ChStdData = 8'h74;  // t
  localparam logic [CharW-1:0] ChExtData = 8'h54;  // T
  localparam logic [CharW-1:0] ChStdRtr  = 8'h72;  // r
  localparam logic [CharW-1:0] ChExtRtr  = 8'h52;  // R
  localparam logic [CharW-1:0] ChZero    = 8'h30;  // 0
  localparam logic [CharW-1:0] ChUpperA  = 8'h41;  // A
  localparam logic [CharW-1:0] ChCr      = 8'h0d;  // carriage return

  // digit counts per field
  localparam logic [CntW-1:0] StdIdDigits = 5'd3;
  localparam logic [CntW-1:0] ExtIdDigits = 5'd8;
  localparam logic [CntW-1:0] TickDigits  = 5'd4;

  // sequencer phases
  localparam logic [2:0] PhLead = 3'd0;
  localparam logic [2:0] PhId   = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhTick = 3'd4;
  localparam logic [2:0] PhCr   = 3'd5;

  // one nibble to an upper-case hex character
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] res;
    if (nib < 4'd10) begin
      res = ChZero + {4'b0, nib};
    end else begin
      res = ChUpperA + {4'b0, nib - 4'd10};
    end
    return res;
  endfunction

endpackage

### src/can_frame_to_slcan_ascii_top.sv
// SLCAN text encoder for received CAN frames.
// Input channel: one frame per request (frame_id, is_extended, is_remote,
// data_length, payload, tick_value), taken when in_valid is high and
// in_stall is low. Output channel: one ASCII character per request
// (ascii_char, is_last), taken when out_valid is high and out_stall is low.
// is_last marks the closing carriage return of each line.
// A line is the type letter, 3 or 8 id digits, the length digit, two digits
// per data byte (none for remote frames, length clamped to 8), four tick
// digits when timestamp_enable is set, then carriage return.
// The first character passes the phase sequencer, then the output register.
// Throughput: one character per cycle while the receiver does not stall, from
// a single nibble shift register and hex converter under a phase sequencer;
// a line has 6 to 31 characters, and the next frame is taken in the cycle the
// carriage return is produced. in_stall stays high while a line is in work.
// A stalled receiver holds the output register and freezes the sequencer.
// cfg_wr_en writes timestamp_enable from cfg_wr_data; write only when idle.
// Reset (rst, synchronous) clears the sequencer, out_valid and
// timestamp_enable; the block is ready in the cycle after reset.
module can_frame_to_slcan_ascii_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cfslc_pkg::IdW-1:0]      frame_id,
  input  logic                           is_extended,
  input  logic                           is_remote,
  input  logic [cfslc_pkg::LenW-1:0]     data_length,
  input  logic [cfslc_pkg::PayW-1:0]     payload,
  input  logic [cfslc_pkg::TickW-1:0]    tick_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cfslc_pkg::CharW-1:0]    ascii_char,
  output logic                           is_last
);

  logic                          timestamp_enable;
  logic                          busy;
  logic [2:0]                    phase;
  logic [cfslc_pkg::CntW-1:0]    cnt;
  logic [cfslc_pkg::PayW-1:0]    work;
  logic [cfslc_pkg::IdW-1:0]     held_id;
  logic [cfslc_pkg::PayW-1:0]    held_payload;
  logic [cfslc_pkg::LenW-1:0]    held_length;
  logic [1:0]                    held_flags;
  logic [cfslc_pkg::TickW-1:0]   held_tick;

  logic                          step;
  logic                          accept;
  logic [cfslc_pkg::CharW-1:0]   char_next;
  logic [cfslc_pkg::LenW-1:0]    len_clamp;

  // sequencer advances when the output register is free
  assign step     = busy && (!out_valid || !out_stall);
  assign in_stall = busy && !(step && (phase == cfslc_pkg::PhCr));
  assign accept   = in_valid && !in_stall;
  assign len_clamp = (data_length > cfslc_pkg::MaxLen) ? cfslc_pkg::MaxLen : data_length;

  // character of the current phase
  always_comb begin
    case (phase)
      cfslc_pkg::PhLead: begin
        if (held_flags[1]) begin
          char_next = held_flags[0] ? cfslc_pkg::ChExtRtr : cfslc_pkg::ChStdRtr;
        end else begin
          char_next = held_flags[0] ? cfslc_pkg::ChExtData : cfslc_pkg::ChStdData;
        end
      end
      cfslc_pkg::PhId, cfslc_pkg::PhData, cfslc_pkg::PhTick: begin
        char_next = cfslc_pkg::hex_char(work[63:60]);
      end
      cfslc_pkg::PhLen: char_next = cfslc_pkg::ChZero + {4'b0, held_length};
      cfslc_pkg::PhCr:  char_next = cfslc_pkg::ChCr;
      default:          char_next = cfslc_pkg::ChCr;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timestamp_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      timestamp_enable <= cfg_wr_data;
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (accept) begin
      held_id      <= frame_id;
      held_payload <= payload;
      held_length  <= len_clamp;
      held_flags   <= {is_remote, is_extended};
      held_tick    <= tick_value;
    end
  end

  // phase sequencer and nibble shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= cfslc_pkg::PhLead;
      cnt   <= '0;
    end else if (accept) begin
      // new frame wins over the end of the previous line
      busy  <= 1'b1;
      phase <= cfslc_pkg::PhLead;
    end else if (step) begin
      case (phase)
        cfslc_pkg::PhLead: begin
          if (held_flags[0]) begin
            // 29-bit id padded to 8 digits
            work <= {3'b0, held_id, 32'b0};
            cnt  <= cfslc_pkg::ExtIdDigits;
          end else begin
            work <= {1'b0, held_id[10:0], 52'b0};
            cnt  <= cfslc_pkg::StdIdDigits;
          end
          phase <= cfslc_pkg::PhId;
        end
        cfslc_pkg::PhId: begin
          work <= {work[59:0], 4'b0};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            phase <= cfslc_pkg::PhLen;
          end
        end
        cfslc_pkg::PhLen: begin
          if (!held_flags[1] && (held_length != '0)) begin
            work  <= held_payload;
            cnt   <= {held_length, 1'b0};
            phase <= cfslc_pkg::PhData;
          end else if (timestamp_enable) begin
            work  <= {held_tick, 48'b0};
            cnt   <= cfslc_pkg::TickDigits;
            phase <= cfslc_pkg::PhTick;
          end else begin
            phase <= cfslc_pkg::PhCr;
          end
        end
        cfslc_pkg::PhData: begin
          if (cnt == 5'd1) begin
            if (timestamp_enable) begin
              work  <= {held_tick, 48'b0};
              cnt   <= cfslc_pkg::TickDigits;
              phase <= cfslc_pkg::PhTick;
            end else begin
              phase <= cfslc_pkg::PhCr;
            end
          end else begin
            work <= {work[59:0], 4'b0};
            cnt  <= cnt - 5'd1;
          end
        end
        cfslc_pkg::PhTick: begin
          work <= {work[59:0], 4'b0};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            phase <= cfslc_pkg::PhCr;
          end
        end
        cfslc_pkg::PhCr: begin
          busy  <= 1'b0;
          phase <= cfslc_pkg::PhLead;
        end
        default: begin
          busy  <= 1'b0;
          phase <= cfslc_pkg::PhLead;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ascii_char <= char_next;
      is_last    <= (phase == cfslc_pkg::PhCr);
    end
  end

endmodule

### src/cfslc_checker.sv
module cfslc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cfslc_pkg::CharW-1:0]   ascii_char,
  input logic                          is_last
);

  // stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ascii_char) && $stable(is_last))
    else $error("stalled output changed");

  // a taken frame keeps the input stalled while its line is built
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request");

  // the last character is always carriage return
  a_last_is_cr: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_last |-> ascii_char == cfslc_pkg::ChCr)
    else $error("last character is not carriage return");

  // carriage return appears only as the last character
  a_cr_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> ascii_char != cfslc_pkg::ChCr)
    else $error("carriage return before end of line");

endmodule

bind can_frame_to_slcan_ascii_top cfslc_checker u_cfslc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .ascii_char (ascii_char),
  .is_last    (is_last)
);

### dv/can_frame_to_slcan_ascii_top_tb.sv
`timescale 1ns / 1ps

module can_frame_to_slcan_ascii_top_tb;

  // one received can frame as it sits on the input ports
  typedef struct packed {
    logic [cfslc_pkg::IdW-1:0]   id;
    logic                        ext;
    logic                        rem;
    logic [cfslc_pkg::LenW-1:0]  len;
    logic [cfslc_pkg::PayW-1:0]  pay;
    logic [cfslc_pkg::TickW-1:0] tick;
  } can_frame_t;

  // one character of a slcan line
  typedef struct packed {
    logic [cfslc_pkg::CharW-1:0] ch;
    logic                        last;
  } slcan_char_t;

  // directed row: timestamp setting, frame, and the line text without the
  // closing carriage return (empty text means the encoder model decides)
  typedef struct {
    bit         ts;
    can_frame_t frame;
    string      text;
  } frame_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic                        cfg_wr_data = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [cfslc_pkg::IdW-1:0]   frame_id = '0;
  logic                        is_extended = 1'b0;
  logic                        is_remote = 1'b0;
  logic [cfslc_pkg::LenW-1:0]  data_length = '0;
  logic [cfslc_pkg::PayW-1:0]  payload = '0;
  logic [cfslc_pkg::TickW-1:0] tick_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [cfslc_pkg::CharW-1:0] ascii_char;
  logic                        is_last;

  slcan_char_t slcan_chars_q[$];
  frame_row_t  frame_rows[$];
  bit          timestamp_on = 1'b0;
  int          fail_count = 0;
  int          frame_gap_pct = 0;
  int          char_stall_pct = 0;
  int          stall_left = 0;

  can_frame_to_slcan_ascii_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_id    (frame_id),
    .is_extended (is_extended),
    .is_remote   (is_remote),
    .data_length (data_length),
    .payload     (payload),
    .tick_value  (tick_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ascii_char  (ascii_char),
    .is_last     (is_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

  // idle length: zero unless the pct chance hits, then a short burst, now and then a long one
  function automatic int pick_idle(int pct);
    int n;
    n = 0;
    if ($urandom_range(0, 99) < pct) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(10, 40);
      end else begin
        n = $urandom_range(1, 3);
      end
    end
    return n;
  endfunction

  function automatic logic [cfslc_pkg::CharW-1:0] nibble_char(logic [3:0] nib);
    string alphabet;
    alphabet = "0123456789ABCDEF";
    return alphabet[nib];
  endfunction

  function automatic void push_char(logic [cfslc_pkg::CharW-1:0] c, logic l);
    slcan_chars_q.push_back('{ch: c, last: l});
  endfunction

  // slcan line encoder: type letter, id digits, length, data, tick, cr
  function automatic void encode_slcan_line(can_frame_t f);
    logic [cfslc_pkg::LenW-1:0] n_bytes;
    logic [cfslc_pkg::CharW-1:0] lead;
    int d;
    int b;
    n_bytes = (f.len > cfslc_pkg::MaxLen) ? cfslc_pkg::MaxLen : f.len;
    if (f.rem) begin
      lead = f.ext ? cfslc_pkg::ChExtRtr : cfslc_pkg::ChStdRtr;
    end else begin
      lead = f.ext ? cfslc_pkg::ChExtData : cfslc_pkg::ChStdData;
    end
    push_char(lead, 1'b0);
    if (f.ext) begin
      for (d = 7; d >= 0; d--) push_char(nibble_char(4'(f.id >> (4 * d))), 1'b0);
    end else begin
      for (d = 2; d >= 0; d--) push_char(nibble_char(4'(f.id[10:0] >> (4 * d))), 1'b0);
    end
    push_char(cfslc_pkg::ChZero + cfslc_pkg::CharW'(n_bytes), 1'b0);
    // data digits follow the length digit only for data frames
    if (!f.rem) begin
      for (b = 0; b < n_bytes; b++) begin
        push_char(nibble_char(f.pay[63 - 8 * b -: 4]), 1'b0);
        push_char(nibble_char(f.pay[59 - 8 * b -: 4]), 1'b0);
      end
    end
    if (timestamp_on) begin
      for (d = 3; d >= 0; d--) push_char(nibble_char(4'(f.tick >> (4 * d))), 1'b0);
    end
    push_char(cfslc_pkg::ChCr, 1'b1);
  endfunction

  function automatic can_frame_t random_frame();
    can_frame_t f;
    f.id   = cfslc_pkg::IdW'($urandom);
    f.ext  = 1'($urandom_range(0, 1));
    f.rem  = ($urandom_range(0, 3) == 0);
    // mostly legal lengths, some above eight to hit the clamp
    f.len  = ($urandom_range(0, 7) == 0) ? cfslc_pkg::LenW'($urandom_range(9, 15))
                                         : cfslc_pkg::LenW'($urandom_range(0, 8));
    f.pay  = {$urandom, $urandom};
    f.tick = cfslc_pkg::TickW'($urandom);
    return f;
  endfunction

  // drive one frame request and record its line once it is taken
  task automatic send_frame(can_frame_t f, string text);
    int gap;
    int k;
    gap = pick_idle(frame_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    frame_id    <= f.id;
    is_extended <= f.ext;
    is_remote   <= f.rem;
    data_length <= f.len;
    payload     <= f.pay;
    tick_value  <= f.tick;
    do @(posedge clk); while (in_stall);
    if (text.len() == 0) begin
      encode_slcan_line(f);
    end else begin
      for (k = 0; k < text.len(); k++) push_char(text[k], 1'b0);
      push_char(cfslc_pkg::ChCr, 1'b1);
    end
  endtask

  // wait for every pending character, then let the block settle
  task automatic drain_lines();
    in_valid <= 1'b0;
    while (slcan_chars_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timestamp_enable(bit en);
    drain_lines();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    timestamp_on = en;
  endtask

  task automatic run_random(bit ts, int gap_pct, int stall_pct, int count);
    write_timestamp_enable(ts);
    frame_gap_pct  = gap_pct;
    char_stall_pct = stall_pct;
    repeat (count) send_frame(random_frame(), "");
  endtask

  // output side: random stall and in-order character check
  always @(posedge clk) begin
    slcan_char_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      if (slcan_chars_q.size() == 0) begin
        $error("unexpected character %h last %b", ascii_char, is_last);
        fail_count++;
      end else begin
        exp_c = slcan_chars_q.pop_front();
        if (ascii_char !== exp_c.ch) begin
          $error("ascii_char mismatch: expected %h, actual %h", exp_c.ch, ascii_char);
          fail_count++;
        end
        if (is_last !== exp_c.last) begin
          $error("is_last mismatch: expected %b, actual %b", exp_c.last, is_last);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_left = pick_idle(char_stall_pct);
    end
    out_stall <= (stall_left > 0);
  end

  initial begin
    can_frame_t f;
    int r;

    // directed frames: extremes, every frame kind, clamp and masking cases
    frame_rows.push_back('{1'b0, '{29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 16'h0}, "t0000"});
    frame_rows.push_back('{1'b0, '{29'h7ff, 1'b0, 1'b0, 4'd8, '1, 16'hffff},
                           {"t7FF8", "FFFFFFFF", "FFFFFFFF"}});
    // standard id prints only its low 11 bits
    frame_rows.push_back('{1'b0, '{29'h1ffff800, 1'b0, 1'b0, 4'd0, 64'h0, 16'h0}, "t0000"});
    frame_rows.push_back('{1'b0, '{29'h1fffffff, 1'b1, 1'b0, 4'd0, 64'h0, 16'h0},
                           {"T", "1FFFFFFF", "0"}});
    frame_rows.push_back('{1'b0, '{29'h0, 1'b1, 1'b1, 4'd8, '1, 16'h0},
                           {"R", "00000000", "8"}});
    frame_rows.push_back('{1'b0, '{29'h123, 1'b0, 1'b1, 4'd4, 64'h1122334455667788, 16'h0},
                           "r1234"});
    // length above eight clamps to eight
    frame_rows.push_back('{1'b0, '{29'h0, 1'b0, 1'b0, 4'd15, 64'h0123456789abcdef, 16'h0},
                           {"t0008", "01234567", "89ABCDEF"}});
    frame_rows.push_back('{1'b0, '{29'h0, 1'b0, 1'b1, 4'd15, '1, 16'h0}, "r0008"});
    frame_rows.push_back('{1'b0, '{29'h0, 1'b0, 1'b0, 4'd1, 64'ha5ffffffffffffff, 16'h0},
                           "t0001A5"});
    frame_rows.push_back('{1'b0, '{29'h12345678, 1'b1, 1'b0, 4'd9, 64'hfedcba9876543210,
                           16'h1234}, ""});
    frame_rows.push_back('{1'b0, '{29'h0aaaaaaa, 1'b1, 1'b0, 4'd3, 64'h5555aaaa5555aaaa,
                           16'h5a5a}, ""});
    frame_rows.push_back('{1'b0, '{29'h15555555, 1'b0, 1'b0, 4'd7, 64'haaaa5555aaaa5555,
                           16'ha5a5}, ""});
    frame_rows.push_back('{1'b1, '{29'h0, 1'b0, 1'b0, 4'd0, 64'h0, 16'h0},
                           {"t000", "0", "0000"}});
    frame_rows.push_back('{1'b1, '{29'h1fffffff, 1'b1, 1'b0, 4'd8, '1, 16'hffff},
                           {"T", "1FFFFFFF", "8", "FFFFFFFF", "FFFFFFFF", "FFFF"}});
    frame_rows.push_back('{1'b1, '{29'h0, 1'b1, 1'b1, 4'd0, 64'h0, 16'habcd},
                           {"R", "00000000", "0", "ABCD"}});
    frame_rows.push_back('{1'b1, '{29'h3c5, 1'b0, 1'b1, 4'd12, 64'h0, 16'h0f0f}, ""});
    frame_rows.push_back('{1'b1, '{29'h0badcafe, 1'b1, 1'b0, 4'd5, 64'hdeadbeef01234567,
                           16'h8001}, ""});
    frame_rows.push_back('{1'b1, '{29'h07e, 1'b0, 1'b0, 4'd2, 64'hc3c3000000000000,
                           16'h7ffe}, ""});
    // timestamp off again: tick is ignored
    frame_rows.push_back('{1'b0, '{29'h7ff, 1'b0, 1'b0, 4'd0, 64'h0, 16'hffff}, "t7FF0"});
    frame_rows.push_back('{1'b0, '{29'h1abcdef0, 1'b1, 1'b1, 4'd6, '1, 16'h4321}, ""});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    frame_gap_pct  = 25;
    char_stall_pct = 25;
    write_timestamp_enable(1'b0);
    for (r = 0; r < frame_rows.size(); r++) begin
      if (frame_rows[r].ts != timestamp_on) begin
        write_timestamp_enable(frame_rows[r].ts);
      end
      send_frame(frame_rows[r].frame, frame_rows[r].text);
    end

    // random phases with varied settings and idling
    run_random(1'b1, 30, 30, 120);
    run_random(1'b0, 0, 0, 80);
    run_random(1'b1, 0, 60, 80);
    run_random(1'b0, 50, 20, 90);
    run_random(1'b1, 10, 0, 80);

    drain_lines();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
src/cfslc_pkg.sv
src/can_frame_to_slcan_ascii_top.sv
src/cfslc_checker.sv
dv/can_frame_to_slcan_ascii_top_tb.sv
